@@ design/lowest_free_id_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Lowest free ID allocator assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LFIA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define LFIA_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define LFIA_ASSERT(lbl, clk, rstn, prop, msg)
`define LFIA_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ design/lfia_pkg.sv @@
// ----------------------------------------------------------------------------
// Lowest free ID allocator package
// Shared codes, widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfia_pkg;

  // One bitmap row holds this many IDs; the bit index is the granted ID field.
  localparam int unsigned ROW_W  = 64;
  localparam int unsigned BIT_AW = 6;
  localparam int unsigned STAT_W = 2;

  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_RELEASE  = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOT_HELD = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

@@ design/lfia_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfia_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lfia_datapath.sv @@
// ----------------------------------------------------------------------------
// Lowest free ID allocator datapath
// Bitmap rows in RAM, per-row full and valid flags, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_macros.svh"

module lfia_datapath #(
  parameter int unsigned ID_COUNT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfia_pkg::cmd_t               cmd_i,
  output lfia_pkg::stat_t              stat_o,
  input  logic                         opcode_i,
  input  logic [lfia_pkg::BIT_AW-1:0]  release_id_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [lfia_pkg::BIT_AW-1:0]  granted_id_o,
  output logic [lfia_pkg::STAT_W-1:0]  status_o
);

  localparam int unsigned ROWS   = (ID_COUNT + lfia_pkg::ROW_W - 1) / lfia_pkg::ROW_W;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RW     = lfia_pkg::ROW_W;
  localparam int unsigned BW     = lfia_pkg::BIT_AW;

  logic [ROWS-1:0]   row_full_q, row_vld_q;
  logic              op_q;
  logic [BW-1:0]     rid_q;
  logic [ROW_AW-1:0] row_q;
  logic              pool_full_q;

  logic              out_valid_q;
  logic [BW-1:0]     granted_q;
  logic [lfia_pkg::STAT_W-1:0] status_q;

  logic [ROW_AW-1:0] free_row, sel_row;
  logic              any_row;
  logic [RW-1:0]     rdata, held_raw, pad, held_eff, alloc_bit, rel_bit, wdata;
  logic [BW-1:0]     free_bit;
  logic              in_pool, rel_hit, is_alloc, we;
  lfia_pkg::status_e res_status;
  logic [BW-1:0]     res_id;

  // Lowest row that still has a free ID.
  always_comb begin
    free_row = '0;
    any_row  = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_q[r]) begin
        free_row = ROW_AW'(r);
        any_row  = 1'b1;
      end
    end
  end

  // Releases can only name IDs below 64, which all live in row zero.
  assign sel_row = (opcode_i == lfia_pkg::OP_RELEASE) ? '0 : free_row;

  lfia_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (sel_row),
    .rdata_o (rdata)
  );

  // A row never written reads as all free.
  assign held_raw = row_vld_q[row_q] ? rdata : '0;

  // IDs past the end of the pool count as held for the search.
  always_comb begin
    for (int j = 0; j < RW; j++) begin
      pad[j] = ({row_q, BW'(j)} >= ID_COUNT);
    end
  end
  assign held_eff = held_raw | pad;

  always_comb begin
    free_bit = '0;
    for (int j = RW - 1; j >= 0; j--) begin
      if (!held_eff[j]) begin
        free_bit = BW'(j);
      end
    end
  end

  assign is_alloc  = (op_q == lfia_pkg::OP_ALLOCATE);
  assign alloc_bit = RW'(1) << free_bit;
  assign rel_bit   = RW'(1) << rid_q;
  assign in_pool   = (rid_q < ID_COUNT);
  assign rel_hit   = in_pool && held_raw[rid_q];
  assign we        = cmd_i.commit && (is_alloc ? !pool_full_q : rel_hit);
  assign wdata     = is_alloc ? (held_raw | alloc_bit) : (held_raw & ~rel_bit);

  always_comb begin
    res_id = '0;
    if (is_alloc) begin
      if (pool_full_q) begin
        res_status = lfia_pkg::STATUS_FULL;
      end else begin
        res_status = lfia_pkg::STATUS_OK;
        res_id     = free_bit;
      end
    end else begin
      res_status = rel_hit ? lfia_pkg::STATUS_OK : lfia_pkg::STATUS_NOT_HELD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_full_q  <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) begin
        row_vld_q[row_q]  <= 1'b1;
        row_full_q[row_q] <= is_alloc ? (&(held_eff | alloc_bit)) : 1'b0;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q        <= opcode_i;
      rid_q       <= release_id_i;
      row_q       <= sel_row;
      pool_full_q <= !any_row;
    end
    if (cmd_i.commit) begin
      granted_q <= res_id;
      status_q  <= res_status;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign granted_id_o    = granted_q;
  assign status_o        = status_q;

  `LFIA_ASSERT(a_full_only_when_rows_full, clk_i, rst_ni,
    (cmd_i.commit && is_alloc && pool_full_q) |-> (&row_full_q),
    "pool reported full while a row still has a free ID")
  `LFIA_ASSERT(a_release_frees_row, clk_i, rst_ni,
    (cmd_i.commit && !is_alloc && rel_hit) |=> !row_full_q[0],
    "row still flagged full after a successful release")

endmodule

@@ design/lfia_ctrl.sv @@
// ----------------------------------------------------------------------------
// Lowest free ID allocator controller
// Sequences each request through bitmap read and update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfia_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lfia_pkg::stat_t stat_i,
  output lfia_pkg::cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.commit = (state_q == ST_EXEC) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/lowest_free_id_allocator.sv @@
// ----------------------------------------------------------------------------
// Lowest free ID allocator
// Hands out the lowest free ID of a pool and takes IDs back.
// ----------------------------------------------------------------------------
// Each input word is a request: opcode 0 allocates, opcode 1 releases the ID
// given on release_id. Each request yields exactly one output word carrying
// granted_id and status (ok, released ID not held, or pool full).
// Both channels use a valid/ready handshake.
//
// The held flags live in a RAM of 64-bit rows. Accepting a request also reads
// the row holding the lowest free ID (row zero for a release). In the execute
// state the row is searched, updated and written back, and the result is
// loaded into the output register; this waits while the register still holds
// an unread word. A new request is taken only once the previous one commits;
// the registered bitmap RAM read splits each request into accept and execute.
//
// Reset empties the pool at once: per-row valid and full flags are cleared
// and a row never written reads as all free, so no clearing pass is needed.
// While the receiver stalls, one finished word waits in the output register
// and the next request is still accepted; its update waits until the
// register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator #(
  parameter int unsigned ID_COUNT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [lfia_pkg::BIT_AW-1:0]  release_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lfia_pkg::BIT_AW-1:0]  granted_id_o,
  output logic [lfia_pkg::STAT_W-1:0]  status_o
);

  lfia_pkg::cmd_t  cmd;
  lfia_pkg::stat_t stat;

  // The controller only decides when a word enters and when a result commits.
  lfia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath owns the bitmap, the search and the output register.
  lfia_datapath #(
    .ID_COUNT (ID_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (opcode_i),
    .release_id_i (release_id_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .granted_id_o (granted_id_o),
    .status_o     (status_o)
  );

  // A request in flight blocks the next one until its result commits.
  `LFIA_ASSERT(a_one_in_flight, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> !in_ready_o,
    "second request accepted while one is in flight")
  // Only a successful allocate may carry a nonzero ID.
  `LFIA_NEVER(a_id_only_on_ok, clk_i, rst_ni,
    out_valid_o && (granted_id_o != '0) && (status_o != lfia_pkg::STATUS_OK),
    "nonzero granted ID with an error status")

endmodule
